@@ design/vdeb_pkg.sv @@
// Shared constants and types for the vertex dedup edge builder.
package vdeb_pkg;

   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_W          = 32;
   localparam int IDX_W            = 10;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] index;
      logic             added;
      logic             overflow;
   } lookup_type;

endpackage

@@ design/vdeb_table.sv @@
// Vertex coordinate store: one write port, one registered read port.
module vdeb_table #(
   parameter int MAX_VERTICES = vdeb_pkg::MAX_VERTICES_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(MAX_VERTICES)-1:0]      wr_addr,
   input  logic [2*vdeb_pkg::COORD_W-1:0]       wr_data,
   input  logic [$clog2(MAX_VERTICES)-1:0]      rd_addr,
   output logic [2*vdeb_pkg::COORD_W-1:0]       rd_data
);

   localparam int DW = 2 * vdeb_pkg::COORD_W;

   logic [DW-1:0] mem [MAX_VERTICES];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/vdeb_scan.sv @@
// Lookup sequencer: walks the table through one shared comparator and appends misses.
module vdeb_scan #(
   parameter int MAX_VERTICES = vdeb_pkg::MAX_VERTICES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic [vdeb_pkg::COORD_W-1:0]      x_coord,
   input  logic [vdeb_pkg::COORD_W-1:0]      y_coord,
   input  logic                              new_layer,
   output vdeb_pkg::lookup_type              result
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int IW = vdeb_pkg::IDX_W;
   localparam int DW = 2 * vdeb_pkg::COORD_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } scan_state_type;

   scan_state_type       state_ff, state_in;
   logic [DW-1:0]        key_ff, key_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        rd_addr_ff, rd_addr_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]        cmp_addr_ff, cmp_addr_in;
   vdeb_pkg::lookup_type res_ff, res_in;

   logic          issue, hit, miss, full, wr_en;
   logic [DW-1:0] rd_data;

   vdeb_table #(.MAX_VERTICES(MAX_VERTICES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_addr (rd_addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign issue = (state_ff == S_SCAN) && (rd_addr_ff < count_ff);
   assign hit   = (state_ff == S_SCAN) && cmp_vld_ff && (rd_data == key_ff);
   assign miss  = (state_ff == S_SCAN) && !issue && !cmp_vld_ff;
   assign full  = (count_ff == CW'(MAX_VERTICES));
   assign wr_en = miss && !full;

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      rd_addr_in  = rd_addr_ff;
      cmp_vld_in  = 1'b0;
      cmp_addr_in = cmp_addr_ff;
      res_in      = res_ff;
      res_in.done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               key_in     = {x_coord, y_coord};
               count_in   = new_layer ? '0 : count_ff;
               rd_addr_in = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            cmp_vld_in  = issue;
            cmp_addr_in = rd_addr_ff[AW-1:0];
            if (issue) begin
               rd_addr_in = rd_addr_ff + CW'(1);
            end
            if (hit || miss) begin
               state_in        = S_IDLE;
               res_in.done     = 1'b1;
               res_in.added    = wr_en;
               res_in.overflow = miss && full;
               if (hit) begin
                  res_in.index = IW'(cmp_addr_ff);
               end else if (full) begin
                  res_in.index = '0;
               end else begin
                  res_in.index = IW'(count_ff);
               end
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         rd_addr_ff  <= '0;
         cmp_vld_ff  <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_addr_ff  <= rd_addr_in;
         cmp_vld_ff  <= cmp_vld_in;
         res_ff.done <= res_in.done;
      end
      key_ff          <= key_in;
      cmp_addr_ff     <= cmp_addr_in;
      res_ff.index    <= res_in.index;
      res_ff.added    <= res_in.added;
      res_ff.overflow <= res_in.overflow;
   end

   assign result = res_ff;

`ifndef SYNTH
   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      rd_addr_ff <= count_ff)
      else $error("scan address beyond table fill");
   a_one_done: assert property (@(posedge clock) disable iff (reset)
      res_ff.done |-> (state_ff == S_IDLE) && !(res_ff.added && res_ff.overflow))
      else $error("lookup done while scanning or both added and overflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("table fill beyond capacity");
`endif

endmodule

@@ design/vertex_dedup_edge_builder.sv @@
// Vertex dedup and indexed edge builder: top level with edge sequencing.
//
// Usage: present a vertex on req_* and raise start; the beat is taken at an
// edge where start is high and busy is low. busy stays high until every
// result of that vertex has been shown.
// Each vertex is matched against the stored table entries one per cycle by a
// single shared comparator fed from the table's registered read port, and the
// first result beat shows once the scan has compared all N entries, N being
// the fill of the table (at most MAX_VERTICES), or earlier on a match. One or
// two result beats follow, one per cycle, marked by rsp_valid: a closing
// vertex that is not also an opening one gives two beats, the second carrying
// the closing edge. The next vertex can be taken at the earliest in the cycle
// after the final beat.
// Reset empties the table and clears the loop start and previous indices to
// zero; the table contents themselves are not cleared, only its fill count.
// Results are shown for exactly one cycle and are taken unconditionally.
module vertex_dedup_edge_builder #(
   parameter int MAX_VERTICES = vdeb_pkg::MAX_VERTICES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [vdeb_pkg::COORD_W-1:0]  req_x_coord,
   input  logic signed [vdeb_pkg::COORD_W-1:0]  req_y_coord,
   input  logic                                 req_loop_first,
   input  logic                                 req_loop_last,
   input  logic                                 req_new_layer,
   output logic                                 rsp_valid,
   output logic [vdeb_pkg::IDX_W-1:0]           rsp_vertex_index,
   output logic                                 rsp_vertex_added,
   output logic                                 rsp_edge_valid,
   output logic [vdeb_pkg::IDX_W-1:0]           rsp_edge_from,
   output logic [vdeb_pkg::IDX_W-1:0]           rsp_edge_to,
   output logic                                 rsp_closing_edge,
   output logic                                 rsp_overflow,
   output logic                                 rsp_last
);

   localparam int IW = vdeb_pkg::IDX_W;

   typedef enum logic [3:0] {
      T_IDLE = 4'b0001,
      T_LOOK = 4'b0010,
      T_OUT1 = 4'b0100,
      T_OUT2 = 4'b1000
   } top_state_type;

   top_state_type        state_ff, state_in;
   logic                 first_ff, first_in;
   logic                 lastv_ff, lastv_in;
   logic [IW-1:0]        loop_start_ff, loop_start_in;
   logic [IW-1:0]        prev_ff, prev_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 added_ff, added_in;
   logic                 ovf_ff, ovf_in;
   logic                 e_valid_ff, e_valid_in;
   logic [IW-1:0]        e_from_ff, e_from_in;
   logic [IW-1:0]        e_to_ff, e_to_in;
   logic                 e_closing_ff, e_closing_in;
   logic                 e_last_ff, e_last_in;
   logic                 two_ff, two_in;

   logic                 accept;
   vdeb_pkg::lookup_type lookup;

   assign accept = start && (state_ff == T_IDLE);
   assign busy   = (state_ff != T_IDLE);

   vdeb_scan #(.MAX_VERTICES(MAX_VERTICES)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .go        (accept),
      .x_coord   (req_x_coord),
      .y_coord   (req_y_coord),
      .new_layer (req_new_layer),
      .result    (lookup)
   );

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      lastv_in      = lastv_ff;
      loop_start_in = loop_start_ff;
      prev_in       = prev_ff;
      idx_in        = idx_ff;
      added_in      = added_ff;
      ovf_in        = ovf_ff;
      e_valid_in    = e_valid_ff;
      e_from_in     = e_from_ff;
      e_to_in       = e_to_ff;
      e_closing_in  = e_closing_ff;
      e_last_in     = e_last_ff;
      two_in        = two_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               first_in = req_loop_first;
               lastv_in = req_loop_last;
               state_in = T_LOOK;
            end
         end
         T_LOOK: begin
            if (lookup.done) begin
               idx_in   = lookup.index;
               added_in = lookup.added;
               ovf_in   = lookup.overflow;
               prev_in  = lookup.index;
               state_in = T_OUT1;
               if (first_ff) begin
                  loop_start_in = lookup.index;
                  e_valid_in    = lastv_ff;
                  e_from_in     = lastv_ff ? lookup.index : '0;
                  e_to_in       = lastv_ff ? lookup.index : '0;
                  e_closing_in  = lastv_ff;
                  e_last_in     = 1'b1;
                  two_in        = 1'b0;
               end else begin
                  e_valid_in    = 1'b1;
                  e_from_in     = prev_ff;
                  e_to_in       = lookup.index;
                  e_closing_in  = 1'b0;
                  e_last_in     = !lastv_ff;
                  two_in        = lastv_ff;
               end
            end
         end
         T_OUT1: begin
            state_in = two_ff ? T_OUT2 : T_IDLE;
         end
         T_OUT2: begin
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         loop_start_ff <= '0;
         prev_ff       <= '0;
         two_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loop_start_ff <= loop_start_in;
         prev_ff       <= prev_in;
         two_ff        <= two_in;
      end
      first_ff     <= first_in;
      lastv_ff     <= lastv_in;
      idx_ff       <= idx_in;
      added_ff     <= added_in;
      ovf_ff       <= ovf_in;
      e_valid_ff   <= e_valid_in;
      e_from_ff    <= e_from_in;
      e_to_ff      <= e_to_in;
      e_closing_ff <= e_closing_in;
      e_last_ff    <= e_last_in;
   end

   assign rsp_valid        = (state_ff == T_OUT1) || (state_ff == T_OUT2);
   assign rsp_vertex_index = idx_ff;
   assign rsp_vertex_added = added_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_edge_valid   = (state_ff == T_OUT2) ? 1'b1 : e_valid_ff;
   assign rsp_edge_from    = (state_ff == T_OUT2) ? idx_ff : e_from_ff;
   assign rsp_edge_to      = (state_ff == T_OUT2) ? loop_start_ff : e_to_ff;
   assign rsp_closing_edge = (state_ff == T_OUT2) ? 1'b1 : e_closing_ff;
   assign rsp_last         = (state_ff == T_OUT2) ? 1'b1 : e_last_ff;

`ifndef SYNTH
   a_second_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_OUT2) |-> $past(state_ff == T_OUT1))
      else $error("closing beat without a preceding edge beat");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result beat after the final beat of a vertex");
   a_done_in_look: assert property (@(posedge clock) disable iff (reset)
      lookup.done |-> (state_ff == T_LOOK))
      else $error("lookup completion outside lookup phase");
`endif

endmodule
